// File: hw/rtl/tlts_pkg.sv
// ---------------------------------------------------------------------------
// tlts_pkg
// Shared types and constants of the token scanner: scan modes, token kind
// codes, reserved word table and the transaction records between modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tlts_pkg;

	localparam int NWORDS  = 18;
	localparam int CNT_W   = 6;
	localparam int KIND_W  = 6;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [NWORDS-1:0] ALL_WORDS = '1;

	// scanner modes, one-hot
	typedef enum logic [8:0] {
		M_START   = 9'b000000001,
		M_COMMENT = 9'b000000010,
		M_NUM     = 9'b000000100,
		M_ID      = 9'b000001000,
		M_COLON   = 9'b000010000,
		M_EQ      = 9'b000100000,
		M_LT      = 9'b001000000,
		M_GT      = 9'b010000000,
		M_MINUS   = 9'b100000000
	} scan_mode_t;

	// token kind codes
	localparam logic [KIND_W-1:0] K_ENDFILE = 6'd0;
	localparam logic [KIND_W-1:0] K_ERROR   = 6'd1;
	localparam logic [KIND_W-1:0] K_WORD0   = 6'd2;
	localparam logic [KIND_W-1:0] K_ID      = 6'd20;
	localparam logic [KIND_W-1:0] K_NUM     = 6'd21;
	localparam logic [KIND_W-1:0] K_RE      = 6'd22;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd23;
	localparam logic [KIND_W-1:0] K_EQ      = 6'd24;
	localparam logic [KIND_W-1:0] K_LT      = 6'd25;
	localparam logic [KIND_W-1:0] K_NE      = 6'd26;
	localparam logic [KIND_W-1:0] K_LE      = 6'd27;
	localparam logic [KIND_W-1:0] K_GT      = 6'd28;
	localparam logic [KIND_W-1:0] K_GE      = 6'd29;
	localparam logic [KIND_W-1:0] K_MINUS   = 6'd30;
	localparam logic [KIND_W-1:0] K_ME      = 6'd31;
	localparam logic [KIND_W-1:0] K_PLUS    = 6'd32;
	localparam logic [KIND_W-1:0] K_TIMES   = 6'd33;
	localparam logic [KIND_W-1:0] K_OVER    = 6'd34;
	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd35;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd36;
	localparam logic [KIND_W-1:0] K_SEMI    = 6'd37;
	localparam logic [KIND_W-1:0] K_MOD     = 6'd38;
	localparam logic [KIND_W-1:0] K_POW     = 6'd39;
	localparam logic [KIND_W-1:0] K_BAR     = 6'd40;
	localparam logic [KIND_W-1:0] K_AMP     = 6'd41;
	localparam logic [KIND_W-1:0] K_HASH    = 6'd42;

	// characters with a meaning of their own
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_EQUAL  = "=";
	localparam logic [7:0] CH_LESS   = "<";
	localparam logic [7:0] CH_MORE   = ">";
	localparam logic [7:0] CH_DASH   = "-";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_PCT    = "%";
	localparam logic [7:0] CH_CARET  = "^";
	localparam logic [7:0] CH_BAR    = "|";
	localparam logic [7:0] CH_AMP    = "&";
	localparam logic [7:0] CH_HASH   = "#";

	// reserved words, right-justified: last letter in the low byte
	localparam logic [63:0] WORD_TEXT [NWORDS] = '{
		64'("if"), 64'("then"), 64'("else"), 64'("end"), 64'("repeat"),
		64'("until"), 64'("read"), 64'("write"), 64'("while"),
		64'("endwhile"), 64'("do"), 64'("for"), 64'("to"), 64'("enddo"),
		64'("downto"), 64'("and"), 64'("or"), 64'("not")
	};
	localparam logic [3:0] WORD_LEN [NWORDS] = '{
		4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5, 4'd5,
		4'd8, 4'd2, 4'd3, 4'd2, 4'd5, 4'd6, 4'd3, 4'd2, 4'd3
	};

	typedef struct packed {
		scan_mode_t        mode;
		logic [CNT_W-1:0]  count;
		logic [NWORDS-1:0] cand;
	} scan_state_t;

	localparam scan_state_t ST_IDLE = '{mode: M_START, count: '0, cand: ALL_WORDS};

	typedef struct packed {
		logic [CNT_W-1:0]  length;
		logic [KIND_W-1:0] kind;
	} token_t;

	// tokens produced by one character
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t tok0;
		token_t tok1;
	} step_res_t;

	typedef struct packed {
		logic   last;
		token_t tok;
	} q_entry_t;

	// does reserved word i have character c at position pos
	function automatic logic word_has(input int i, input logic [CNT_W-1:0] pos,
	                                  input logic [7:0] c);
		logic [CNT_W-1:0] len;
		logic [2:0]       idx;
		logic             hit;
		len = {2'b00, WORD_LEN[i]};
		hit = 1'b0;
		if (pos < len) begin
			idx = 3'(len - 6'd1 - pos);
			hit = (WORD_TEXT[i][{idx, 3'b000} +: 8] == c);
		end
		return hit;
	endfunction

	// single-character operators, error otherwise
	function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_PLUS:   k = K_PLUS;
			CH_STAR:   k = K_TIMES;
			CH_SLASH:  k = K_OVER;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_SEMI:   k = K_SEMI;
			CH_PCT:    k = K_MOD;
			CH_CARET:  k = K_POW;
			CH_BAR:    k = K_BAR;
			CH_AMP:    k = K_AMP;
			CH_HASH:   k = K_HASH;
			default:   k = K_ERROR;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tlts_step.sv
// ---------------------------------------------------------------------------
// tlts_step
// Next-state and token logic for one character: the mode handler and, for
// a backed-up character, a second pass through the start state.
// ---------------------------------------------------------------------------
`default_nettype none

module tlts_step #(
	parameter int TOKEN_TEXT_MAX = 40
) (
	input  wire logic [7:0]           ch,
	input  wire logic                 eoi,
	input  wire tlts_pkg::scan_state_t st,
	output tlts_pkg::scan_state_t     st_next,
	output tlts_pkg::step_res_t       res
);

	localparam logic [tlts_pkg::CNT_W-1:0] TMAX = tlts_pkg::CNT_W'(TOKEN_TEXT_MAX);

	typedef struct packed {
		logic                  emit;
		tlts_pkg::token_t      tok;
		tlts_pkg::scan_state_t nxt;
	} pass_t;

	// save a character: narrow the keyword mask, bump the count
	function automatic tlts_pkg::scan_state_t save(input tlts_pkg::scan_state_t s,
	                                                input logic [7:0] c);
		tlts_pkg::scan_state_t r;
		r = s;
		if (s.count <= TMAX) begin
			for (int i = 0; i < tlts_pkg::NWORDS; i++) begin
				if (!tlts_pkg::word_has(i, s.count, c))
					r.cand[i] = 1'b0;
			end
			r.count = s.count + 6'd1;
		end
		return r;
	endfunction

	// start-state handling of one character
	function automatic pass_t start_pass(input logic e, input logic [7:0] c,
	                                     input tlts_pkg::scan_state_t s,
	                                     input tlts_pkg::scan_state_t sv);
		pass_t r;
		r.emit = 1'b0;
		r.tok  = '{length: s.count, kind: tlts_pkg::K_ENDFILE};
		r.nxt  = s;
		r.nxt.mode = tlts_pkg::M_START;
		if (e) begin
			r.emit = 1'b1;
			r.nxt  = tlts_pkg::ST_IDLE;
		end else if (c >= "0" && c <= "9") begin
			r.nxt      = sv;
			r.nxt.mode = tlts_pkg::M_NUM;
		end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
			r.nxt      = sv;
			r.nxt.mode = tlts_pkg::M_ID;
		end else if (c == tlts_pkg::CH_SPACE || c == tlts_pkg::CH_TAB ||
		             c == tlts_pkg::CH_NL) begin
			r.nxt.mode = tlts_pkg::M_START;
		end else if (c == tlts_pkg::CH_LBRACE) begin
			r.nxt.mode = tlts_pkg::M_COMMENT;
		end else begin
			r.nxt = sv;
			case (c)
				tlts_pkg::CH_COLON: r.nxt.mode = tlts_pkg::M_COLON;
				tlts_pkg::CH_EQUAL: r.nxt.mode = tlts_pkg::M_EQ;
				tlts_pkg::CH_LESS:  r.nxt.mode = tlts_pkg::M_LT;
				tlts_pkg::CH_MORE:  r.nxt.mode = tlts_pkg::M_GT;
				tlts_pkg::CH_DASH:  r.nxt.mode = tlts_pkg::M_MINUS;
				default: begin
					r.emit = 1'b1;
					r.tok  = '{length: sv.count, kind: tlts_pkg::op_kind(c)};
					r.nxt  = tlts_pkg::ST_IDLE;
				end
			endcase
		end
		return r;
	endfunction

	// identifier end: first surviving word of the right length
	function automatic logic [tlts_pkg::KIND_W-1:0] ident_kind(
		input tlts_pkg::scan_state_t s);
		logic [tlts_pkg::KIND_W-1:0] k;
		k = tlts_pkg::K_ID;
		for (int i = tlts_pkg::NWORDS - 1; i >= 0; i--) begin
			if (s.cand[i] && {2'b00, tlts_pkg::WORD_LEN[i]} == s.count)
				k = tlts_pkg::K_WORD0 + tlts_pkg::KIND_W'(i);
		end
		return k;
	endfunction

	tlts_pkg::scan_state_t sv_cur;
	tlts_pkg::scan_state_t sv_fresh;
	pass_t                 p_cur;
	pass_t                 p_back;
	logic                  is_dig;
	logic                  is_alp;
	logic                  is_sp;
	logic                  is_eq;
	logic                  emit0;
	logic                  backup;
	tlts_pkg::token_t      tok0;
	tlts_pkg::scan_state_t nxt0;

	// saves and start passes from the current and from the idle state
	always_comb begin
		sv_cur   = save(st, ch);
		sv_fresh = save(tlts_pkg::ST_IDLE, ch);
		p_cur    = start_pass(eoi, ch, st, sv_cur);
		p_back   = start_pass(eoi, ch, tlts_pkg::ST_IDLE, sv_fresh);
		is_dig   = !eoi && ch >= "0" && ch <= "9";
		is_alp   = !eoi && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"));
		is_sp    = !eoi && ch == tlts_pkg::CH_SPACE;
		is_eq    = !eoi && ch == tlts_pkg::CH_EQUAL;
	end

	// mode handler
	always_comb begin
		emit0  = 1'b0;
		backup = 1'b0;
		tok0   = '{length: st.count, kind: tlts_pkg::K_ERROR};
		nxt0   = tlts_pkg::ST_IDLE;
		unique case (st.mode)
			tlts_pkg::M_COMMENT: begin
				nxt0 = st;
				if (eoi) begin
					emit0 = 1'b1;
					tok0.kind = tlts_pkg::K_ENDFILE;
					nxt0 = tlts_pkg::ST_IDLE;
				end else if (ch == tlts_pkg::CH_RBRACE) begin
					nxt0.mode = tlts_pkg::M_START;
				end
			end
			tlts_pkg::M_NUM: begin
				if (is_dig) begin
					nxt0 = sv_cur;
				end else begin
					emit0 = 1'b1;
					backup = 1'b1;
					tok0.kind = tlts_pkg::K_NUM;
				end
			end
			tlts_pkg::M_ID: begin
				if (is_alp) begin
					nxt0 = sv_cur;
				end else begin
					emit0 = 1'b1;
					backup = 1'b1;
					tok0.kind = ident_kind(st);
				end
			end
			tlts_pkg::M_COLON: begin
				emit0 = 1'b1;
				if (is_eq)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_RE};
				else
					backup = 1'b1;
			end
			tlts_pkg::M_EQ: begin
				emit0 = 1'b1;
				if (is_sp)
					tok0.kind = tlts_pkg::K_ASSIGN;
				else if (is_eq)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_EQ};
				else
					backup = 1'b1;
			end
			tlts_pkg::M_LT: begin
				emit0 = 1'b1;
				if (is_sp)
					tok0.kind = tlts_pkg::K_LT;
				else if (!eoi && ch == tlts_pkg::CH_MORE)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_NE};
				else if (is_eq)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_LE};
				else
					backup = 1'b1;
			end
			tlts_pkg::M_GT: begin
				emit0 = 1'b1;
				if (is_sp)
					tok0.kind = tlts_pkg::K_GT;
				else if (is_eq)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_GE};
				else
					backup = 1'b1;
			end
			tlts_pkg::M_MINUS: begin
				emit0 = 1'b1;
				if (is_sp)
					tok0.kind = tlts_pkg::K_MINUS;
				else if (is_eq)
					tok0 = '{length: sv_cur.count, kind: tlts_pkg::K_ME};
				else
					backup = 1'b1;
			end
			default: begin
				emit0 = p_cur.emit;
				tok0  = p_cur.tok;
				nxt0  = p_cur.nxt;
			end
		endcase
	end

	// a backed-up character goes through the start state again
	always_comb begin
		res.v0   = emit0;
		res.v1   = backup && p_back.emit;
		res.tok0 = tok0;
		res.tok1 = p_back.tok;
		st_next  = backup ? p_back.nxt : nxt0;
	end

endmodule

`default_nettype wire

// File: hw/rtl/tlts_outq.sv
// ---------------------------------------------------------------------------
// tlts_outq
// Four-entry token queue: takes up to two tokens per cycle, hands one per
// cycle to the output stream while out_ready is high, and marks the last
// token of each character.
`default_nettype none

module tlts_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tlts_pkg::step_res_t res,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tlts_pkg::q_entry_t       out_entry
);

	tlts_pkg::q_entry_t        entry_q [tlts_pkg::Q_DEPTH];
	logic [tlts_pkg::Q_AW-1:0] wr_q;
	logic [tlts_pkg::Q_AW-1:0] rd_q;
	logic [tlts_pkg::Q_AW:0]   fill_q;
	logic                      pop;
	logic                      w0;
	logic                      w1;
	logic [1:0]                n_push;

	// write and read strobes
	always_comb begin
		pop    = out_valid && out_ready;
		w0     = push && res.v0;
		w1     = push && res.v0 && res.v1;
		n_push = {1'b0, w0} + {1'b0, w1};
	end

	// storage
	always_ff @(posedge clk) begin
		if (w0)
			entry_q[wr_q] <= '{last: !w1, tok: res.tok0};
		if (w1)
			entry_q[wr_q + 2'd1] <= '{last: 1'b1, tok: res.tok1};
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + n_push;
			rd_q   <= rd_q + {1'b0, pop};
			fill_q <= fill_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

	assign room      = fill_q <= 3'(tlts_pkg::Q_DEPTH - 2);
	assign out_valid = fill_q != '0;
	assign out_entry = entry_q[rd_q];

endmodule

`default_nettype wire

// File: hw/rtl/tiny_language_token_scanner.sv
// ---------------------------------------------------------------------------
// tiny_language_token_scanner
// Lexical scanner for a small teaching language, one character per
// transaction, emitting token kind and saved length.
// ---------------------------------------------------------------------------
// Output: tokens reach m_tvalid through the four-entry token queue, in order.
// Throughput: one character per cycle while s_tready shows queue room; a
//   character that gives two tokens hands them out one after the other.
// Reset: arst_n clears scanner state to the start state and empties the queue.
`default_nettype none

module tiny_language_token_scanner #(
	parameter int TOKEN_TEXT_MAX = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic [0:0]  s_tuser,   // [0] end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [5:0] token_kind, [11:6] token_length
	output logic             m_tlast
);

	tlts_pkg::scan_state_t state_q;
	tlts_pkg::scan_state_t state_next;
	tlts_pkg::step_res_t   res;
	tlts_pkg::q_entry_t    head;
	logic                  accept;

	assign accept = s_tvalid && s_tready;

	// character step logic
	tlts_step #(
		.TOKEN_TEXT_MAX (TOKEN_TEXT_MAX)
	) u_step (
		.ch      (s_tdata),
		.eoi     (s_tuser[0]),
		.st      (state_q),
		.st_next (state_next),
		.res     (res)
	);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tlts_pkg::ST_IDLE;
		else if (accept)
			state_q <= state_next;
	end

	// token queue towards the output stream
	tlts_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.res       (res),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_entry (head)
	);

	assign m_tdata = {4'b0000, head.tok.length, head.tok.kind};
	assign m_tlast = head.last;

endmodule

`default_nettype wire

// File: test/tiny_language_token_scanner_check.sv
// ---------------------------------------------------------------------------
// tiny_language_token_scanner_check
// Watches both stream channels of the token scanner. Every accepted character
// is run through a scanner state machine of its own, and the tokens it gives
// are queued. Each token the block hands out is compared field by field with
// the oldest queued one.
// ---------------------------------------------------------------------------

module tiny_language_token_scanner_check #(
	parameter int TOKEN_TEXT_MAX = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] end_of_input
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [5:0] token_kind, [11:6] token_length
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [tlts_pkg::KIND_W-1:0] kind;
		logic [tlts_pkg::CNT_W-1:0]  length;
		logic                        last;
	} token_exp_t;

	// reserved words in kind order
	string words [tlts_pkg::NWORDS] = '{
		"if", "then", "else", "end", "repeat", "until", "read", "write", "while",
		"endwhile", "do", "for", "to", "enddo", "downto", "and", "or", "not"
	};

	// predicted scanner state
	tlts_pkg::scan_mode_t        mode;
	int unsigned                 saved;
	logic [tlts_pkg::NWORDS-1:0] cand;

	token_exp_t tokens_due[$];
	token_exp_t step_tok[2];
	int         step_n;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// save a character and narrow the reserved word candidates
	function automatic void keep_char(input logic [7:0] c);
		if (saved > TOKEN_TEXT_MAX)
			return;
		for (int i = 0; i < tlts_pkg::NWORDS; i++) begin
			if (saved >= words[i].len() || words[i][saved] != c)
				cand[i] = 1'b0;
		end
		saved++;
	endfunction

	function automatic void give_token(input logic [tlts_pkg::KIND_W-1:0] kind);
		if (step_n < 2) begin
			step_tok[step_n] = '{kind: kind, length: tlts_pkg::CNT_W'(saved), last: 1'b0};
			step_n++;
		end
		saved = 0;
		cand  = tlts_pkg::ALL_WORDS;
		mode  = tlts_pkg::M_START;
	endfunction

	function automatic logic [tlts_pkg::KIND_W-1:0] word_kind();
		for (int i = 0; i < tlts_pkg::NWORDS; i++) begin
			if (cand[i] && words[i].len() == saved)
				return tlts_pkg::K_WORD0 + tlts_pkg::KIND_W'(i);
		end
		return tlts_pkg::K_ID;
	endfunction

	function automatic logic [tlts_pkg::KIND_W-1:0] single_kind(input logic [7:0] c);
		case (c)
			tlts_pkg::CH_PLUS:   return tlts_pkg::K_PLUS;
			tlts_pkg::CH_STAR:   return tlts_pkg::K_TIMES;
			tlts_pkg::CH_SLASH:  return tlts_pkg::K_OVER;
			tlts_pkg::CH_LPAREN: return tlts_pkg::K_LPAREN;
			tlts_pkg::CH_RPAREN: return tlts_pkg::K_RPAREN;
			tlts_pkg::CH_SEMI:   return tlts_pkg::K_SEMI;
			tlts_pkg::CH_PCT:    return tlts_pkg::K_MOD;
			tlts_pkg::CH_CARET:  return tlts_pkg::K_POW;
			tlts_pkg::CH_BAR:    return tlts_pkg::K_BAR;
			tlts_pkg::CH_AMP:    return tlts_pkg::K_AMP;
			tlts_pkg::CH_HASH:   return tlts_pkg::K_HASH;
			default:             return tlts_pkg::K_ERROR;
		endcase
	endfunction

	// character seen in the start state
	function automatic void start_char(input logic eof, input logic [7:0] c);
		if (eof)
			give_token(tlts_pkg::K_ENDFILE);
		else if (is_digit(c)) begin
			keep_char(c);
			mode = tlts_pkg::M_NUM;
		end else if (is_letter(c)) begin
			keep_char(c);
			mode = tlts_pkg::M_ID;
		end else if (c == tlts_pkg::CH_SPACE || c == tlts_pkg::CH_TAB ||
		             c == tlts_pkg::CH_NL) begin
		end else if (c == tlts_pkg::CH_LBRACE)
			mode = tlts_pkg::M_COMMENT;
		else begin
			keep_char(c);
			case (c)
				tlts_pkg::CH_COLON: mode = tlts_pkg::M_COLON;
				tlts_pkg::CH_EQUAL: mode = tlts_pkg::M_EQ;
				tlts_pkg::CH_LESS:  mode = tlts_pkg::M_LT;
				tlts_pkg::CH_MORE:  mode = tlts_pkg::M_GT;
				tlts_pkg::CH_DASH:  mode = tlts_pkg::M_MINUS;
				default:            give_token(single_kind(c));
			endcase
		end
	endfunction

	// one accepted character: advance the state and queue its tokens
	function automatic void scan_char(input logic eof, input logic [7:0] c);
		logic again;
		logic sp;
		logic eq;
		again = 1'b0;
		sp    = !eof && c == tlts_pkg::CH_SPACE;
		eq    = !eof && c == tlts_pkg::CH_EQUAL;
		step_n = 0;
		case (mode)
			tlts_pkg::M_COMMENT: begin
				if (eof)
					give_token(tlts_pkg::K_ENDFILE);
				else if (c == tlts_pkg::CH_RBRACE)
					mode = tlts_pkg::M_START;
			end
			tlts_pkg::M_NUM: begin
				if (!eof && is_digit(c))
					keep_char(c);
				else begin
					give_token(tlts_pkg::K_NUM);
					again = 1'b1;
				end
			end
			tlts_pkg::M_ID: begin
				if (!eof && is_letter(c))
					keep_char(c);
				else begin
					give_token(word_kind());
					again = 1'b1;
				end
			end
			tlts_pkg::M_COLON: begin
				if (eq) begin
					keep_char(c);
					give_token(tlts_pkg::K_RE);
				end else
					again = 1'b1;
			end
			tlts_pkg::M_EQ: begin
				if (sp)
					give_token(tlts_pkg::K_ASSIGN);
				else if (eq) begin
					keep_char(c);
					give_token(tlts_pkg::K_EQ);
				end else
					again = 1'b1;
			end
			tlts_pkg::M_LT: begin
				if (sp)
					give_token(tlts_pkg::K_LT);
				else if (!eof && c == tlts_pkg::CH_MORE) begin
					keep_char(c);
					give_token(tlts_pkg::K_NE);
				end else if (eq) begin
					keep_char(c);
					give_token(tlts_pkg::K_LE);
				end else
					again = 1'b1;
			end
			tlts_pkg::M_GT: begin
				if (sp)
					give_token(tlts_pkg::K_GT);
				else if (eq) begin
					keep_char(c);
					give_token(tlts_pkg::K_GE);
				end else
					again = 1'b1;
			end
			tlts_pkg::M_MINUS: begin
				if (sp)
					give_token(tlts_pkg::K_MINUS);
				else if (eq) begin
					keep_char(c);
					give_token(tlts_pkg::K_ME);
				end else
					again = 1'b1;
			end
			default: begin
				mode = tlts_pkg::M_START;
				start_char(eof, c);
			end
		endcase
		// incomplete operator: error token before the backed-up character
		if (again && mode != tlts_pkg::M_START)
			give_token(tlts_pkg::K_ERROR);
		if (again)
			start_char(eof, c);
		for (int i = 0; i < step_n; i++) begin
			step_tok[i].last = (i == step_n - 1);
			tokens_due.push_back(step_tok[i]);
		end
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		token_exp_t want;
		if (!arst_n) begin
			mode  = tlts_pkg::M_START;
			saved = 0;
			cand  = tlts_pkg::ALL_WORDS;
			tokens_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				scan_char(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected token, expected none, got kind %0d length %0d last %0b",
						$time, m_tdata[5:0], m_tdata[11:6], m_tlast);
				end else begin
					want = tokens_due.pop_front();
					if (m_tdata[5:0] != want.kind || m_tdata[11:6] != want.length ||
							m_tlast != want.last) begin
						mismatches++;
						$display("%0t: token mismatch, expected kind %0d length %0d last %0b,",
							$time, want.kind, want.length, want.last);
						$display("%0t:   got kind %0d length %0d last %0b",
							$time, m_tdata[5:0], m_tdata[11:6], m_tlast);
					end
				end
			end
			pending <= tokens_due.size();
		end
	end

endmodule

// File: test/tiny_language_token_scanner_test.sv
// ---------------------------------------------------------------------------
// tiny_language_token_scanner_test
// Drives the token scanner with a short directed source text and then a long
// stream of random tokens, operators, comments and noise bytes, with random
// gaps on both channels. The checker beside the block reports mismatches.
// ---------------------------------------------------------------------------

module tiny_language_token_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEXT_MAX   = 40;
	localparam int CHAR_COUNT = 1650;
	localparam int LIMIT      = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // [7:0] ch
	logic [0:0]  s_tuser = '0;      // [0] end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [5:0] token_kind, [11:6] token_length
	logic        m_tlast;

	int   mismatches;
	int   pending;
	int   sent = 0;
	int   cycles = 0;
	logic calm = 1'b0;

	string vocab [tlts_pkg::NWORDS] = '{
		"if", "then", "else", "end", "repeat", "until", "read", "write", "while",
		"endwhile", "do", "for", "to", "enddo", "downto", "and", "or", "not"
	};
	string pairs [10] = '{":=", "==", "= ", "<>", "<=", "< ", ">=", "> ", "-=", "- "};
	string singles = "+*/();%^|&#";
	string op_heads = ":=<>-";

	always #5 clk = ~clk;

	tiny_language_token_scanner #(
		.TOKEN_TEXT_MAX(TEXT_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	tiny_language_token_scanner_check #(
		.TOKEN_TEXT_MAX(TEXT_MAX)
	) i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stalls
	always @(posedge clk)
		m_tready <= calm || $urandom_range(99) >= 7;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one character transaction, with random idle cycles ahead of it
	task automatic put_char(input logic [7:0] c, input logic eof);
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= eof;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], 1'b0);
	endtask

	task automatic put_eof();
		put_char(8'($urandom_range(255)), 1'b1);
	endtask

	// letters or digits; now and then longer than the saved text
	task automatic put_run(input bit digits);
		int n;
		logic [7:0] c;
		n = ($urandom_range(39) == 0) ? $urandom_range(38, 50) : $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			if (digits)
				c = "0" + 8'($urandom_range(9));
			else
				c = ($urandom_range(1) ? "A" : "a") + 8'($urandom_range(25));
			put_char(c, 1'b0);
		end
	endtask

	// a reserved word, exact or slightly off
	task automatic put_word();
		string w;
		int    n;
		logic [7:0] c;
		w = vocab[$urandom_range(tlts_pkg::NWORDS - 1)];
		n = w.len();
		case ($urandom_range(4))
			2: n = n - 1;
			3: n = n + $urandom_range(1, 2);
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			c = (i < w.len()) ? w[i] : "a" + 8'($urandom_range(25));
			if (i == 0 && $urandom_range(7) == 0)
				c = c - 8'd32;
			put_char(c, 1'b0);
		end
	endtask

	// what follows a word or a number
	task automatic put_gap();
		case ($urandom_range(5))
			0: put_char(tlts_pkg::CH_SPACE, 1'b0);
			1: put_char(tlts_pkg::CH_TAB, 1'b0);
			2: put_char(tlts_pkg::CH_NL, 1'b0);
			3: put_char(singles[$urandom_range(singles.len() - 1)], 1'b0);
			4: put_char(8'($urandom_range(255)), 1'b0);
			default: ;
		endcase
	endtask

	task automatic put_comment();
		logic [7:0] c;
		put_char(tlts_pkg::CH_LBRACE, 1'b0);
		repeat ($urandom_range(6)) begin
			c = 8'($urandom_range(255));
			if (c == tlts_pkg::CH_RBRACE)
				c = "a";
			put_char(c, 1'b0);
		end
		put_char(tlts_pkg::CH_RBRACE, 1'b0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keywords, two-character operators, end of input inside a
		// token, inside an operator and inside a comment, repeated end marks,
		// high bytes, carriage return and a zero byte
		put_text("if :=<>x");
		put_eof();
		put_text("-");
		put_eof();
		put_text("{a");
		put_eof();
		put_eof();
		put_char(8'hFF, 1'b0);
		put_char(8'h0D, 1'b0);
		put_char(8'h00, 1'b0);
		put_char(8'h80, 1'b0);
		put_text("downto 9;");

		// random source text, with a stretch free of idle cycles
		while (sent < CHAR_COUNT) begin
			calm = (sent >= 700 && sent < 1000);
			case ($urandom_range(15))
				0, 1, 2: begin
					put_word();
					put_gap();
				end
				3, 4: begin
					put_run(1'b0);
					put_gap();
				end
				5, 6: begin
					put_run(1'b1);
					put_gap();
				end
				7, 8: put_text(pairs[$urandom_range(9)]);
				9: begin
					put_char(op_heads[$urandom_range(op_heads.len() - 1)], 1'b0);
					put_char(8'($urandom_range(255)), 1'b0);
				end
				10, 11: put_char(singles[$urandom_range(singles.len() - 1)], 1'b0);
				12: put_comment();
				13: put_char(8'($urandom_range(255)), 1'b0);
				14: put_gap();
				default: begin
					if ($urandom_range(3) == 0)
						put_eof();
					else
						put_char(8'($urandom_range(255)), 1'b0);
				end
			endcase
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then a short tail for stray tokens
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/tlts_pkg.sv
hw/rtl/tlts_step.sv
hw/rtl/tlts_outq.sv
hw/rtl/tiny_language_token_scanner.sv
test/tiny_language_token_scanner_check.sv
test/tiny_language_token_scanner_test.sv
